// ===== hw/rtl/memory_region_protection_table_core_defines.svh =====
// assertion macros for the memory region protection table core
// used by the top level; expects clk and arst_n in the including scope
`ifndef MEMORY_REGION_PROTECTION_TABLE_CORE_DEFINES_SVH
`define MEMORY_REGION_PROTECTION_TABLE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MRPT_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MRPT_ASSERT_NEVER(name, cond, msg) `MRPT_ASSERT(name, !(cond), msg)
`else
`define MRPT_ASSERT(name, prop, msg)
`define MRPT_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ===== hw/rtl/mrpt_pkg.sv =====
// shared types, codes and sizes of the memory region protection table
// no dependencies
`default_nettype none
package mrpt_pkg;
	localparam int REGIONS = 16;
	localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int CNT_W = $clog2(REGIONS + 1);
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-3:0] REG_ENFORCE = '0;

	// command codes on the request port
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_VERIFY = 3'd2;
	localparam logic [2:0] CMD_LOOKUP = 3'd3;
	localparam logic [2:0] CMD_VALIDATE = 3'd4;
	localparam logic [2:0] CMD_CLEAR = 3'd5;

	// status codes on the result port
	localparam logic [2:0] STAT_OK = 3'd0;
	localparam logic [2:0] STAT_FULL = 3'd1;
	localparam logic [2:0] STAT_OVERLAP = 3'd2;
	localparam logic [2:0] STAT_NOTFOUND = 3'd3;
	localparam logic [2:0] STAT_ZERO = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD, OP_REMOVE, OP_VERIFY, OP_LOOKUP, OP_VALIDATE, OP_CLEAR, OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SHIFT, S_VAL_RD, S_VAL_LD, S_RESP
	} state_t;

	// classified request, with the range end taken at 65 bits
	typedef struct packed {
		op_t op;
		logic [63:0] base;
		logic [64:0] end_addr;
		logic [7:0] perms;
		logic [3:0] kind;
		logic [63:0] cap;
	} cmd_t;

	// one table entry as held in the memory
	typedef struct packed {
		logic [63:0] base;
		logic [64:0] end_addr;
		logic [7:0] perms;
		logic [3:0] kind;
		logic [63:0] cap;
	} entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
	} eng_status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mrpt_ram.sv =====
// generic single write port, single read port memory with registered read
// no dependencies
`default_nettype none
module mrpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/mrpt_front.sv =====
// request front end: classifies requests and queues them for the engine
// depends on mrpt_pkg
`default_nettype none
module mrpt_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [2:0] command,
	input  logic [63:0] base_addr,
	input  logic [63:0] length,
	input  logic [7:0] perms,
	input  logic [3:0] region_kind,
	input  logic [63:0] region_cap,
	output logic cmd_valid,
	output mrpt_pkg::cmd_t cmd,
	input  logic take
);
	mrpt_pkg::cmd_t fifo_q [mrpt_pkg::CMDQ_DEPTH];
	mrpt_pkg::cmd_t new_cmd;
	logic [mrpt_pkg::CMDQ_PTR_W-1:0] wr_q, rd_q;
	logic [mrpt_pkg::CMDQ_CNT_W-1:0] cnt_q;
	logic accept, deq;

	// decode the command code
	always_comb begin
		unique case (command)
			mrpt_pkg::CMD_ADD: new_cmd.op = mrpt_pkg::OP_ADD;
			mrpt_pkg::CMD_REMOVE: new_cmd.op = mrpt_pkg::OP_REMOVE;
			mrpt_pkg::CMD_VERIFY: new_cmd.op = mrpt_pkg::OP_VERIFY;
			mrpt_pkg::CMD_LOOKUP: new_cmd.op = mrpt_pkg::OP_LOOKUP;
			mrpt_pkg::CMD_VALIDATE: new_cmd.op = mrpt_pkg::OP_VALIDATE;
			mrpt_pkg::CMD_CLEAR: new_cmd.op = mrpt_pkg::OP_CLEAR;
			default: new_cmd.op = mrpt_pkg::OP_NOP;
		endcase
		new_cmd.base = base_addr;
		new_cmd.end_addr = {1'b0, base_addr} + {1'b0, length};
		new_cmd.perms = perms;
		new_cmd.kind = region_kind;
		new_cmd.cap = region_cap;
	end

	assign full = (cnt_q == mrpt_pkg::CMDQ_CNT_W'(mrpt_pkg::CMDQ_DEPTH));
	assign accept = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign deq = take && cmd_valid;
	assign cmd = fifo_q[rd_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wr_q <= (wr_q == mrpt_pkg::CMDQ_PTR_W'(mrpt_pkg::CMDQ_DEPTH - 1)) ?
					'0 : wr_q + mrpt_pkg::CMDQ_PTR_W'(1);
			end
			if (deq) begin
				rd_q <= (rd_q == mrpt_pkg::CMDQ_PTR_W'(mrpt_pkg::CMDQ_DEPTH - 1)) ?
					'0 : rd_q + mrpt_pkg::CMDQ_PTR_W'(1);
			end
			if (accept && !deq) begin
				cnt_q <= cnt_q + mrpt_pkg::CMDQ_CNT_W'(1);
			end else if (deq && !accept) begin
				cnt_q <= cnt_q - mrpt_pkg::CMDQ_CNT_W'(1);
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			fifo_q[wr_q] <= new_cmd;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/mrpt_engine.sv =====
// table engine: scans, appends, shifts and validates the region table
// depends on mrpt_pkg and mrpt_ram
`default_nettype none
module mrpt_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic enforce,
	input  logic cmd_valid,
	input  mrpt_pkg::cmd_t cmd,
	output logic take,
	output logic empty,
	input  logic pop,
	output logic [2:0] status,
	output logic granted,
	output logic hit,
	output logic [3:0] hit_index,
	output logic [3:0] hit_kind,
	output logic [7:0] hit_perms,
	output logic [63:0] hit_cap,
	output mrpt_pkg::eng_status_t eng_status
);
	localparam int IW = mrpt_pkg::IDX_W;
	localparam int CW = mrpt_pkg::CNT_W;

	mrpt_pkg::state_t state_q, state_d;
	mrpt_pkg::cmd_t cmd_q;
	mrpt_pkg::entry_t rdata, wdata;
	logic [CW-1:0] count_q, rd_ptr_q, outer_q;
	logic chk_vld_s1;
	logic [IW-1:0] chk_idx_s1, waddr, raddr;
	logic [IW+3:0] idx_ext;
	logic we, issue, scan_hit, scan_miss, shift_done, load_out, out_valid_q;
	logic ge_base, lt_end, end_gt_base, end_le_end, same_base, match;
	logic perm_ok, entry_zero, table_full;
	logic [2:0] pend_status_q, status_q;
	logic pend_granted_q, pend_hit_q, granted_q, hit_q;
	logic [3:0] pend_idx_q, pend_kind_q, idx_q, kind_q;
	logic [7:0] pend_perms_q, perms_q;
	logic [63:0] pend_cap_q, cap_q;

	mrpt_ram #(
		.WIDTH($bits(mrpt_pkg::entry_t)),
		.DEPTH(mrpt_pkg::REGIONS)
	) u_table (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// compare the held request against the entry on the read port
	assign ge_base = cmd_q.base >= rdata.base;
	assign lt_end = {1'b0, cmd_q.base} < rdata.end_addr;
	assign end_gt_base = cmd_q.end_addr > {1'b0, rdata.base};
	assign end_le_end = cmd_q.end_addr <= rdata.end_addr;
	assign same_base = cmd_q.base == rdata.base;
	assign perm_ok = (rdata.perms & cmd_q.perms) == cmd_q.perms;
	assign entry_zero = rdata.end_addr == {1'b0, rdata.base};
	assign idx_ext = {4'b0000, chk_idx_s1};
	assign table_full = count_q >= CW'(mrpt_pkg::REGIONS);

	always_comb begin
		case (cmd_q.op) inside
			mrpt_pkg::OP_ADD, mrpt_pkg::OP_VALIDATE: match = lt_end && end_gt_base;
			mrpt_pkg::OP_REMOVE: match = same_base;
			mrpt_pkg::OP_VERIFY: match = ge_base && end_le_end;
			mrpt_pkg::OP_LOOKUP: match = ge_base && lt_end;
			default: match = 1'b0;
		endcase
	end

	// scan pipeline events
	assign issue = ((state_q == mrpt_pkg::S_SCAN) || (state_q == mrpt_pkg::S_SHIFT))
		&& (rd_ptr_q < count_q);
	assign scan_hit = (state_q == mrpt_pkg::S_SCAN) && chk_vld_s1 && match;
	assign scan_miss = (state_q == mrpt_pkg::S_SCAN) && !chk_vld_s1 && !issue;
	assign shift_done = (state_q == mrpt_pkg::S_SHIFT) && !chk_vld_s1 && !issue;
	assign load_out = (state_q == mrpt_pkg::S_RESP) && (!out_valid_q || pop);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrpt_pkg::S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						mrpt_pkg::OP_ADD:
							state_d = table_full ? mrpt_pkg::S_RESP : mrpt_pkg::S_SCAN;
						mrpt_pkg::OP_VERIFY:
							state_d = enforce ? mrpt_pkg::S_SCAN : mrpt_pkg::S_RESP;
						mrpt_pkg::OP_REMOVE, mrpt_pkg::OP_LOOKUP: state_d = mrpt_pkg::S_SCAN;
						mrpt_pkg::OP_VALIDATE: state_d = mrpt_pkg::S_VAL_RD;
						default: state_d = mrpt_pkg::S_RESP;
					endcase
				end
			end
			mrpt_pkg::S_SCAN: begin
				if (scan_hit) begin
					state_d = (cmd_q.op == mrpt_pkg::OP_REMOVE) ?
						mrpt_pkg::S_SHIFT : mrpt_pkg::S_RESP;
				end else if (scan_miss) begin
					state_d = (cmd_q.op == mrpt_pkg::OP_VALIDATE) ?
						mrpt_pkg::S_VAL_RD : mrpt_pkg::S_RESP;
				end
			end
			mrpt_pkg::S_SHIFT: begin
				if (shift_done) begin
					state_d = mrpt_pkg::S_RESP;
				end
			end
			mrpt_pkg::S_VAL_RD: begin
				state_d = (outer_q >= count_q) ? mrpt_pkg::S_RESP : mrpt_pkg::S_VAL_LD;
			end
			mrpt_pkg::S_VAL_LD: begin
				state_d = entry_zero ? mrpt_pkg::S_RESP : mrpt_pkg::S_SCAN;
			end
			mrpt_pkg::S_RESP: begin
				if (load_out) begin
					state_d = mrpt_pkg::S_IDLE;
				end
			end
			default: state_d = mrpt_pkg::S_IDLE;
		endcase
	end

	// memory control and request take
	always_comb begin
		take = (state_q == mrpt_pkg::S_IDLE) && cmd_valid;
		raddr = (state_q == mrpt_pkg::S_VAL_RD) ? outer_q[IW-1:0] : rd_ptr_q[IW-1:0];
		we = 1'b0;
		waddr = count_q[IW-1:0];
		wdata = '{base: cmd_q.base, end_addr: cmd_q.end_addr, perms: cmd_q.perms,
			kind: cmd_q.kind, cap: cmd_q.cap};
		if ((state_q == mrpt_pkg::S_SHIFT) && chk_vld_s1) begin
			we = 1'b1;
			waddr = chk_idx_s1 - IW'(1);
			wdata = rdata;
		end else if (scan_miss && (cmd_q.op == mrpt_pkg::OP_ADD)) begin
			we = 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrpt_pkg::S_IDLE;
			count_q <= '0;
			rd_ptr_q <= '0;
			outer_q <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				rd_ptr_q <= '0;
				outer_q <= '0;
				chk_vld_s1 <= 1'b0;
				if (cmd.op == mrpt_pkg::OP_CLEAR) begin
					count_q <= '0;
				end
			end
			if ((state_q == mrpt_pkg::S_SCAN) || (state_q == mrpt_pkg::S_SHIFT)) begin
				chk_vld_s1 <= issue;
				chk_idx_s1 <= rd_ptr_q[IW-1:0];
				if (issue) begin
					rd_ptr_q <= rd_ptr_q + CW'(1);
				end
			end
			if (scan_miss && (cmd_q.op == mrpt_pkg::OP_ADD)) begin
				count_q <= count_q + CW'(1);
			end
			if (scan_miss && (cmd_q.op == mrpt_pkg::OP_VALIDATE)) begin
				outer_q <= outer_q + CW'(1);
			end
			if (shift_done) begin
				count_q <= count_q - CW'(1);
			end
			if (state_q == mrpt_pkg::S_VAL_LD) begin
				rd_ptr_q <= outer_q + CW'(1);
				chk_vld_s1 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request hold, pending result and result register
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd;
			pend_status_q <= ((cmd.op == mrpt_pkg::OP_ADD) && table_full) ?
				mrpt_pkg::STAT_FULL : mrpt_pkg::STAT_OK;
			pend_granted_q <= (cmd.op == mrpt_pkg::OP_VERIFY) && !enforce;
			pend_hit_q <= 1'b0;
			pend_idx_q <= '0;
			pend_kind_q <= '0;
			pend_perms_q <= '0;
			pend_cap_q <= '0;
		end
		if (scan_hit) begin
			case (cmd_q.op) inside
				mrpt_pkg::OP_ADD, mrpt_pkg::OP_VALIDATE: pend_status_q <= mrpt_pkg::STAT_OVERLAP;
				mrpt_pkg::OP_VERIFY: pend_granted_q <= perm_ok;
				mrpt_pkg::OP_LOOKUP: begin
					pend_hit_q <= 1'b1;
					pend_idx_q <= idx_ext[3:0];
					pend_kind_q <= rdata.kind;
					pend_perms_q <= rdata.perms;
					pend_cap_q <= rdata.cap;
				end
				default: ;
			endcase
		end
		if (scan_miss) begin
			case (cmd_q.op) inside
				mrpt_pkg::OP_REMOVE, mrpt_pkg::OP_LOOKUP: pend_status_q <= mrpt_pkg::STAT_NOTFOUND;
				default: ;
			endcase
		end
		// validate: entry i becomes the range checked against later entries
		if (state_q == mrpt_pkg::S_VAL_LD) begin
			cmd_q.base <= rdata.base;
			cmd_q.end_addr <= rdata.end_addr;
			if (entry_zero) begin
				pend_status_q <= mrpt_pkg::STAT_ZERO;
			end
		end
		if (load_out) begin
			status_q <= pend_status_q;
			granted_q <= pend_granted_q;
			hit_q <= pend_hit_q;
			idx_q <= pend_idx_q;
			kind_q <= pend_kind_q;
			perms_q <= pend_perms_q;
			cap_q <= pend_cap_q;
		end
	end

	assign empty = !out_valid_q;
	assign status = status_q;
	assign granted = granted_q;
	assign hit = hit_q;
	assign hit_index = idx_q;
	assign hit_kind = kind_q;
	assign hit_perms = perms_q;
	assign hit_cap = cap_q;
	assign eng_status.count = count_q;
endmodule
`default_nettype wire

// ===== hw/rtl/memory_region_protection_table_core.sv =====
// Memory region protection table core.
// Requests enter through a queue-style port (push/full) and are classified into a
// two-entry request queue; the engine takes them one at a time and places one
// result per request on a queue-style result port (empty/pop). Results stay on
// the ports while empty is low; a stalled receiver holds the engine in its
// result stage, and requests keep queueing until full rises.
// The table lives in a 16-entry memory with registered read; the engine reads
// one entry per cycle. Add, remove, verify and lookup scan the stored regions;
// a hit ends the scan early, and remove then shifts the later entries down.
// Clear, unused codes, add to a full table and verify with enforcement off go
// straight to the result stage; validate compares each stored region with the
// later ones in its pairwise scan.
// The result shows in the cycle after it is loaded; a request that arrives
// with the engine idle is taken in the cycle after it is pushed.
// enforce_enable sits at APB byte address 0; pready is always high.
// Reset empties the table count, both queues, and clears enforce_enable.
// Depends on mrpt_pkg, mrpt_front, mrpt_engine and the assertion macro header.
`default_nettype none
`include "memory_region_protection_table_core_defines.svh"
module memory_region_protection_table_core (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [2:0] command,
	input  logic [63:0] base_addr,
	input  logic [63:0] length,
	input  logic [7:0] perms,
	input  logic [3:0] region_kind,
	input  logic [63:0] region_cap,
	output logic empty,
	input  logic pop,
	output logic [2:0] status,
	output logic granted,
	output logic hit,
	output logic [3:0] hit_index,
	output logic [3:0] hit_kind,
	output logic [7:0] hit_perms,
	output logic [63:0] hit_cap,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mrpt_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [mrpt_pkg::APB_DATA_W-1:0] pwdata,
	output logic [mrpt_pkg::APB_DATA_W-1:0] prdata,
	output logic pready
);
	logic enforce_q, cmd_valid, take, reg_sel;
	mrpt_pkg::cmd_t cmd;
	mrpt_pkg::eng_status_t eng_status;

	// configuration register
	assign pready = 1'b1;
	assign reg_sel = paddr[mrpt_pkg::APB_ADDR_W-1:2] == mrpt_pkg::REG_ENFORCE;
	assign prdata = reg_sel ? {{(mrpt_pkg::APB_DATA_W-1){1'b0}}, enforce_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enforce_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			enforce_q <= pwdata[0];
		end
	end

	mrpt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.base_addr(base_addr),
		.length(length),
		.perms(perms),
		.region_kind(region_kind),
		.region_cap(region_cap),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.take(take)
	);

	mrpt_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.enforce(enforce_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.take(take),
		.empty(empty),
		.pop(pop),
		.status(status),
		.granted(granted),
		.hit(hit),
		.hit_index(hit_index),
		.hit_kind(hit_kind),
		.hit_perms(hit_perms),
		.hit_cap(hit_cap),
		.eng_status(eng_status)
	);

	// checks
	`MRPT_ASSERT(a_count_bound, eng_status.count <= mrpt_pkg::CNT_W'(mrpt_pkg::REGIONS), "table count above capacity")
	`MRPT_ASSERT_NEVER(a_hit_and_grant, !empty && hit && granted, "lookup hit and verify grant together")
	`MRPT_ASSERT(a_hit_ok, (!empty && hit) |-> (status == mrpt_pkg::STAT_OK), "lookup hit with error status")
endmodule
`default_nettype wire
